// ===== rtl/core/cld_pkg.sv =====
// Shared types, register indexes and constants of the channel/length frame deframer.
package cld_pkg;

	// Header layout: one channel id byte, then a 32-bit big-endian length
	localparam int unsigned HDR_BYTES = 5;
	localparam int unsigned LEN_W     = 32;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned HCNT_W    = 3;
	localparam int unsigned CFG_IDX_W = 3;

	// Default depth of the queue between the parser and the result stage
	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	// Register reset values
	localparam logic [LEN_W-1:0]  MAX_LEN_RST  = 32'd1048576;
	localparam logic [BYTE_W-1:0] VIDEO_ID_RST = 8'd0;
	localparam logic [BYTE_W-1:0] AUDIO_ID_RST = 8'd1;
	localparam logic [BYTE_W-1:0] CTRL_ID_RST  = 8'd2;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_LEN  = 3'd0,
		REG_VIDEO_ID = 3'd1,
		REG_AUDIO_ID = 3'd2,
		REG_CTRL_ID  = 3'd3
	} cld_reg_e_t;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_PAYLOAD  = 2'd0,
		KIND_EMPTY    = 2'd1,
		KIND_OVERSIZE = 2'd2
	} cld_kind_t;

	// Parser phases
	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_FAILED  = 2'd2
	} cld_phase_t;

	// Configuration register file as seen by the datapath
	typedef struct packed {
		logic [LEN_W-1:0]  max_len;
		logic [BYTE_W-1:0] video_id;
		logic [BYTE_W-1:0] audio_id;
		logic [BYTE_W-1:0] ctrl_id;
	} cld_cfg_t;

	// Classified item handed from the parser to the result stage
	typedef struct packed {
		cld_kind_t         kind;
		logic [BYTE_W-1:0] channel;
		logic [BYTE_W-1:0] payload_byte;
		logic              last;
	} cld_entry_t;

endpackage

// ===== rtl/core/cld_ifs.sv =====
// Valid/ready channel interfaces: received bytes, results and register writes.
interface cld_byte_if
	import cld_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cld_result_if
	import cld_pkg::*;
	();
	logic              valid;
	logic              ready;
	cld_kind_t         kind;
	logic [BYTE_W-1:0] channel;
	logic              known_channel;
	logic [BYTE_W-1:0] payload_byte;
	logic              last;

	modport source (output valid, output kind, output channel, output known_channel,
		output payload_byte, output last, input ready);
	modport sink   (input valid, input kind, input channel, input known_channel,
		input payload_byte, input last, output ready);
endinterface

interface cld_cfg_if
	import cld_pkg::*;
	();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [LEN_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/cld_front.sv =====
// Header parser: accepts bytes, assembles the header, classifies each byte.
module cld_front
	import cld_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	cld_byte_if.sink       rx,
	input  cld_cfg_t       cfg,
	input  logic           q_full,
	output logic           push,
	output cld_entry_t     entry
);

	cld_phase_t         phase_q, phase_d;
	logic [HCNT_W-1:0]  hcount_q, hcount_d;
	logic [BYTE_W-1:0]  frame_channel_q, frame_channel_d;
	logic [LEN_W-1:0]   length_shift_q, length_shift_d;
	logic [LEN_W-1:0]   bytes_left_q, bytes_left_d;
	logic [LEN_W-1:0]   len_next;
	logic               accept;
	logic               fin;

	localparam logic [HCNT_W-1:0] HCNT_LAST = HCNT_W'(HDR_BYTES - 1);

	// Take a byte whenever the queue has room
	assign rx.ready = ~q_full;
	assign accept   = rx.valid & rx.ready;

	// Shift the next length byte in; the id byte restarts the length
	assign len_next = (hcount_q == '0) ? '0 : {length_shift_q[LEN_W-BYTE_W-1:0], rx.rx_byte};
	assign fin      = (bytes_left_q[LEN_W-1:1] == '0);

	// Hold parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_HEADER;
			hcount_q        <= '0;
			frame_channel_q <= '0;
			length_shift_q  <= '0;
			bytes_left_q    <= '0;
		end else begin
			phase_q         <= phase_d;
			hcount_q        <= hcount_d;
			frame_channel_q <= frame_channel_d;
			length_shift_q  <= length_shift_d;
			bytes_left_q    <= bytes_left_d;
		end
	end

	// Advance the parser and classify the accepted byte
	always_comb begin
		phase_d              = phase_q;
		hcount_d             = hcount_q;
		frame_channel_d      = frame_channel_q;
		length_shift_d       = length_shift_q;
		bytes_left_d         = bytes_left_q;
		push                 = 1'b0;
		entry.kind           = KIND_PAYLOAD;
		entry.channel        = frame_channel_q;
		entry.payload_byte   = '0;
		entry.last           = 1'b0;
		case (phase_q)
			PH_HEADER: begin
				if (accept) begin
					if (hcount_q == '0) begin
						frame_channel_d = rx.rx_byte;
					end
					length_shift_d = len_next;
					if (hcount_q == HCNT_LAST) begin
						hcount_d = '0;
						if (len_next > cfg.max_len) begin
							phase_d    = PH_FAILED;
							push       = 1'b1;
							entry.kind = KIND_OVERSIZE;
						end else if (len_next == '0) begin
							push       = 1'b1;
							entry.kind = KIND_EMPTY;
							entry.last = 1'b1;
						end else begin
							bytes_left_d = len_next;
							phase_d      = PH_PAYLOAD;
						end
					end else begin
						hcount_d = hcount_q + 1'b1;
					end
				end
			end
			PH_PAYLOAD: begin
				if (accept) begin
					push               = 1'b1;
					entry.kind         = KIND_PAYLOAD;
					entry.payload_byte = rx.rx_byte;
					entry.last         = fin;
					if (fin) begin
						bytes_left_d = '0;
						phase_d      = PH_HEADER;
						hcount_d     = '0;
					end else begin
						bytes_left_d = bytes_left_q - 1'b1;
					end
				end
			end
			default: begin
				// failed stream: drop every byte
			end
		endcase
	end

	a_failed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_FAILED |=> phase_q == PH_FAILED)
		else $error("failed state left before reset");

	a_push_needs_accept: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> accept)
		else $error("result pushed without an accepted byte");

	a_hcount_range: assert property (@(posedge clk) disable iff (!arst_n)
		hcount_q <= HCNT_LAST)
		else $error("header byte count out of range");

	a_payload_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> bytes_left_q != '0)
		else $error("payload phase with no bytes left");

endmodule

// ===== rtl/core/cld_queue.sv =====
// Short queue of classified items between the parser and the result stage.
module cld_queue
	import cld_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  cld_entry_t push_entry,
	input  logic       pop,
	output logic       full,
	output logic       q_valid,
	output cld_entry_t q_entry
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	cld_entry_t        mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign full     = (count_q == CNT_FULL);
	assign q_valid  = (count_q != '0);
	assign q_entry  = mem_q[rd_ptr_q];
	assign do_push  = push & ~full;
	assign do_pop   = pop & q_valid;

	// Store pushed items
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into a full queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("queue occupancy out of range");

	a_push_visible: assert property (@(posedge clk) disable iff (!arst_n)
		do_push |=> q_valid)
		else $error("pushed item not visible");

endmodule

// ===== rtl/core/cld_back.sv =====
// Result stage: matches the channel against configured ids, drives the output register.
module cld_back
	import cld_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  cld_cfg_t      cfg,
	input  logic          q_valid,
	input  cld_entry_t    q_entry,
	output logic          pop,
	cld_result_if.source  res
);

	logic              valid_q;
	cld_kind_t         kind_q;
	logic [BYTE_W-1:0] channel_q;
	logic              known_q;
	logic [BYTE_W-1:0] payload_byte_q;
	logic              last_q;
	logic              known;

	// Load the output register when it is empty or being drained
	assign pop   = q_valid & (~valid_q | res.ready);
	assign known = (q_entry.channel == cfg.video_id) |
		(q_entry.channel == cfg.audio_id) |
		(q_entry.channel == cfg.ctrl_id);

	// Hold the output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Capture the result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q         <= q_entry.kind;
			channel_q      <= q_entry.channel;
			known_q        <= known;
			payload_byte_q <= q_entry.payload_byte;
			last_q         <= q_entry.last;
		end
	end

	assign res.valid         = valid_q;
	assign res.kind          = kind_q;
	assign res.channel       = channel_q;
	assign res.known_channel = known_q;
	assign res.payload_byte  = payload_byte_q;
	assign res.last          = last_q;

	a_pop_fills: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> valid_q)
		else $error("popped item not presented");

	a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !res.ready |-> !pop)
		else $error("item popped over a stalled result");

	a_non_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && kind_q != KIND_PAYLOAD |-> payload_byte_q == '0)
		else $error("non-payload result carries a payload byte");

endmodule

// ===== rtl/core/channel_length_frame_deframer_core.sv =====
// A result's item passes through the queue and then the output register before it is valid.
// Throughput: one byte per cycle unless res stalls; the parser, the item queue and the output
// register each take one item per cycle, so header bytes and payload bytes stream back to back.
// Reset: arst_n clears the parser to header phase, empties the queue and output,
// and loads the register defaults (max length 1048576, ids 0, 1, 2).
module channel_length_frame_deframer_core
	import cld_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	cld_byte_if.sink      rx,
	cld_result_if.source  res,
	cld_cfg_if.sink       cfg
);

	cld_cfg_t   cfg_q;
	logic       q_full;
	logic       push;
	cld_entry_t push_entry;
	logic       pop;
	logic       q_valid;
	cld_entry_t q_entry;
	cld_reg_e_t wr_index;

	assign cfg.ready = 1'b1;
	assign wr_index  = cld_reg_e_t'(cfg.index);

	// Write configuration registers; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_len  <= MAX_LEN_RST;
			cfg_q.video_id <= VIDEO_ID_RST;
			cfg_q.audio_id <= AUDIO_ID_RST;
			cfg_q.ctrl_id  <= CTRL_ID_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (wr_index)
				REG_MAX_LEN:  cfg_q.max_len  <= cfg.data;
				REG_VIDEO_ID: cfg_q.video_id <= cfg.data[BYTE_W-1:0];
				REG_AUDIO_ID: cfg_q.audio_id <= cfg.data[BYTE_W-1:0];
				REG_CTRL_ID:  cfg_q.ctrl_id  <= cfg.data[BYTE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	cld_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.cfg    (cfg_q),
		.q_full (q_full),
		.push   (push),
		.entry  (push_entry)
	);

	cld_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (q_full),
		.q_valid    (q_valid),
		.q_entry    (q_entry)
	);

	cld_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_entry (q_entry),
		.pop     (pop),
		.res     (res)
	);

endmodule

// ===== tb/cld_deframe_checker.sv =====
// Checker: watches the byte, result and register channels, predicts deframed output and compares.
module cld_deframe_checker
	import cld_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	cld_byte_if    rx,
	cld_result_if  res,
	cld_cfg_if     cfg,
	output int     errors,
	output int     pending
);

	// One predicted output transaction
	typedef struct packed {
		cld_kind_t         kind;
		logic [BYTE_W-1:0] channel;
		logic              known;
		logic [BYTE_W-1:0] data;
		logic              last;
	} deframed_t;

	deframed_t deframed_q[$];

	// Register copies
	logic [LEN_W-1:0]  lim_len;
	logic [BYTE_W-1:0] id_video;
	logic [BYTE_W-1:0] id_audio;
	logic [BYTE_W-1:0] id_ctrl;

	// Parser state
	cld_phase_t        ph;
	logic [HCNT_W-1:0] hdr_cnt;
	logic [BYTE_W-1:0] frame_ch;
	logic [LEN_W-1:0]  len_acc;
	logic [LEN_W-1:0]  remaining;

	int res_count;

	task automatic report(input string msg);
		errors++;
		$display("%0t ERROR %s", $time, msg);
	endtask

	task automatic queue_out(input cld_kind_t kind, input logic [BYTE_W-1:0] data,
		input logic last);
		deframed_t d;
		d.kind    = kind;
		d.channel = frame_ch;
		d.known   = (frame_ch == id_video) || (frame_ch == id_audio) || (frame_ch == id_ctrl);
		d.data    = data;
		d.last    = last;
		deframed_q.insert(deframed_q.size(), d);
	endtask

	// Advance the parser by one received byte
	task automatic parse_byte(input logic [BYTE_W-1:0] b);
		logic fin;
		case (ph)
			PH_HEADER: begin
				if (hdr_cnt == '0) begin
					frame_ch = b;
					len_acc  = '0;
				end else begin
					len_acc = {len_acc[LEN_W-BYTE_W-1:0], b};
				end
				hdr_cnt = hdr_cnt + 1'b1;
				if (hdr_cnt == HDR_BYTES) begin
					hdr_cnt = '0;
					if (len_acc > lim_len) begin
						ph = PH_FAILED;
						queue_out(KIND_OVERSIZE, '0, 1'b0);
					end else if (len_acc == '0) begin
						queue_out(KIND_EMPTY, '0, 1'b1);
					end else begin
						remaining = len_acc;
						ph        = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				fin = (remaining <= 1);
				queue_out(KIND_PAYLOAD, b, fin);
				if (fin) begin
					remaining = '0;
					ph        = PH_HEADER;
					hdr_cnt   = '0;
				end else begin
					remaining = remaining - 1'b1;
				end
			end
			// failed stream: drop the byte
			default: ;
		endcase
	endtask

	// Compare one accepted result with the oldest prediction
	task automatic check_result();
		deframed_t want;
		if (deframed_q.size() == 0) begin
			report($sformatf("result %0d arrived with nothing predicted (kind %0d channel 0x%0h)",
				res_count, res.kind, res.channel));
		end else begin
			want = deframed_q.pop_front();
			if (res.kind !== want.kind)
				report($sformatf("result %0d kind: got %0d, want %0d",
					res_count, res.kind, want.kind));
			if (res.channel !== want.channel)
				report($sformatf("result %0d channel: got 0x%0h, want 0x%0h",
					res_count, res.channel, want.channel));
			if (res.known_channel !== want.known)
				report($sformatf("result %0d known_channel: got %0b, want %0b",
					res_count, res.known_channel, want.known));
			if (res.payload_byte !== want.data)
				report($sformatf("result %0d payload_byte: got 0x%0h, want 0x%0h",
					res_count, res.payload_byte, want.data));
			if (res.last !== want.last)
				report($sformatf("result %0d last: got %0b, want %0b",
					res_count, res.last, want.last));
		end
		res_count++;
	endtask

	// Sample every channel at the clock edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deframed_q.delete();
			lim_len   = MAX_LEN_RST;
			id_video  = VIDEO_ID_RST;
			id_audio  = AUDIO_ID_RST;
			id_ctrl   = CTRL_ID_RST;
			ph        = PH_HEADER;
			hdr_cnt   = '0;
			frame_ch  = '0;
			len_acc   = '0;
			remaining = '0;
			res_count = 0;
			errors    = 0;
			pending  <= 0;
		end else begin
			if (res.valid && res.ready)
				check_result();
			if (rx.valid && rx.ready)
				parse_byte(rx.rx_byte);
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_MAX_LEN:  lim_len  = cfg.data;
					REG_VIDEO_ID: id_video = cfg.data[BYTE_W-1:0];
					REG_AUDIO_ID: id_audio = cfg.data[BYTE_W-1:0];
					REG_CTRL_ID:  id_ctrl  = cfg.data[BYTE_W-1:0];
					default: ;
				endcase
			end
			pending <= deframed_q.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top: clock, reset, byte and register stimulus, receiver stalls and the verdict.
module tb_top;
	import cld_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_GAP   = 4;

	logic clk = 1'b0;
	logic arst_n;

	cld_byte_if   rx_ch();
	cld_result_if res_ch();
	cld_cfg_if    cfg_ch();

	int fail_count;
	int pending;
	int cycles;
	int sent_count;
	int send_idle_pct;
	int recv_stall_pct;

	logic [LEN_W-1:0]  cur_max;
	logic [BYTE_W-1:0] cur_video;
	logic [BYTE_W-1:0] cur_audio;
	logic [BYTE_W-1:0] cur_ctrl;

	channel_length_frame_deframer_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	cld_deframe_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx_ch),
		.res     (res_ch),
		.cfg     (cfg_ch),
		.errors  (fail_count),
		.pending (pending)
	);

	always #5 clk = ~clk;

	// Stall the result channel at the current rate
	always @(posedge clk) begin
		res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Offer one byte, with a random gap first, and hold it until accepted
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		if ($urandom_range(99) < send_idle_pct) begin
			rx_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (!rx_ch.ready);
		sent_count++;
	endtask

	task automatic send_header(input logic [BYTE_W-1:0] ch, input logic [LEN_W-1:0] len);
		send_byte(ch);
		send_byte(len[31:24]);
		send_byte(len[23:16]);
		send_byte(len[15:8]);
		send_byte(len[7:0]);
	endtask

	task automatic send_frame(input logic [BYTE_W-1:0] ch, input logic [LEN_W-1:0] len);
		logic [BYTE_W-1:0] b;
		send_header(ch, len);
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom);
			// favor the byte extremes now and then
			case ($urandom_range(7))
				0: b = 8'h00;
				1: b = 8'hFF;
				default: ;
			endcase
			send_byte(b);
		end
	endtask

	// Send well-formed frames of random content until the byte goal is reached
	task automatic run_frames(input int byte_goal, input int len_cap);
		int start;
		int len;
		logic [BYTE_W-1:0] ch;
		start = sent_count;
		while (sent_count - start < byte_goal) begin
			case ($urandom_range(3))
				0: ch = cur_video;
				1: ch = cur_audio;
				2: ch = cur_ctrl;
				default: ch = 8'($urandom);
			endcase
			len = $urandom_range(len_cap);
			if ($urandom_range(9) == 0)
				len = len_cap;
			send_frame(ch, len);
		end
	endtask

	task automatic stop_rx();
		rx_ch.valid <= 1'b0;
	endtask

	// Wait until every predicted result has come, then let the pipeline settle
	task automatic await_drain();
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	// Write all registers; id writes carry junk in the unused upper bits
	task automatic load_config(input logic [LEN_W-1:0] max_len, input logic [BYTE_W-1:0] vid,
		input logic [BYTE_W-1:0] aid, input logic [BYTE_W-1:0] cid);
		put_reg(REG_MAX_LEN, max_len);
		put_reg(REG_VIDEO_ID, {24'($urandom), vid});
		put_reg(REG_AUDIO_ID, {24'($urandom), aid});
		put_reg(REG_CTRL_ID, {24'($urandom), cid});
		// a write past the register list must change nothing
		put_reg(3'(REG_CTRL_ID) + 3'($urandom_range(1, 4)), $urandom);
		cfg_ch.valid <= 1'b0;
		cur_max   = max_len;
		cur_video = vid;
		cur_audio = aid;
		cur_ctrl  = cid;
	endtask

	initial begin
		arst_n         = 1'b0;
		cycles         = 0;
		sent_count     = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		rx_ch.valid    = 1'b0;
		rx_ch.rx_byte  = '0;
		res_ch.ready   = 1'b0;
		cfg_ch.valid   = 1'b0;
		cfg_ch.index   = '0;
		cfg_ch.data    = '0;
		cur_max        = MAX_LEN_RST;
		cur_video      = VIDEO_ID_RST;
		cur_audio      = AUDIO_ID_RST;
		cur_ctrl       = CTRL_ID_RST;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Defaults, no idling: directed frames first
		send_frame(8'h00, 1);
		send_frame(8'hFF, 0);
		send_header(8'h02, 3);
		send_byte(8'h00);
		send_byte(8'h5A);
		send_byte(8'hA5);
		send_frame(8'h01, 2);
		run_frames(100, 12);
		stop_rx();
		await_drain();

		// Small maximum, lengths up to and equal to it; sender idles
		load_config(6, 8'($urandom), 8'($urandom), 8'($urandom));
		send_idle_pct = 60;
		run_frames(110, 6);
		stop_rx();
		await_drain();

		// Largest maximum, all ids equal; receiver stalls
		load_config('1, 8'hFF, 8'hFF, 8'hFF);
		send_idle_pct  = 0;
		recv_stall_pct = 60;
		run_frames(110, 24);
		stop_rx();
		await_drain();

		// Random maximum and ids; both sides idle lightly
		load_config($urandom_range(10, 40), 8'($urandom), 8'($urandom), 8'($urandom));
		send_idle_pct  = 11;
		recv_stall_pct = 11;
		run_frames(110, cur_max);
		stop_rx();
		await_drain();

		// No idling; hold the sender until everything has come out, then resume
		load_config(20, 8'($urandom), 8'h00, 8'($urandom));
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		run_frames(50, 20);
		stop_rx();
		await_drain();
		run_frames(50, 20);
		stop_rx();
		await_drain();

		// Zero maximum: an empty frame passes, an oversize length fails the stream for good
		load_config(0, 8'hFF, 8'h00, 8'h80);
		recv_stall_pct = 60;
		send_frame(8'($urandom), 0);
		send_header(8'($urandom), '1);
		repeat (12) send_byte(8'($urandom));
		stop_rx();
		await_drain();

		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
